// File: hdl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// shared types, constants and round functions of the chacha20 stream cipher
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;

    // input queue between front and back, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam logic [5:0] LAST_POS = 6'd63;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] block_t;

    typedef enum logic [2:0] {
        REG_KEY_0_7    = 3'd0,
        REG_KEY_8_15   = 3'd1,
        REG_KEY_16_23  = 3'd2,
        REG_KEY_24_31  = 3'd3,
        REG_NONCE_0_7  = 3'd4,
        REG_NONCE_8_11 = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } item_t;

    typedef struct packed {
        logic  start;
        logic  abort;
        word_t counter;
    } core_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t counter;
    } core_rsp_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } core_state_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    function automatic word_t rotl32(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // one half of a quarter round: two add-xor-rotate steps
    function automatic quad_t half_qr(quad_t q, logic second);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        quad_t r;
        a = q.a + q.b;
        d = q.d ^ a;
        d = second ? rotl32(d, 8) : rotl32(d, 16);
        c = q.c + d;
        b = q.b ^ c;
        b = second ? rotl32(b, 7) : rotl32(b, 12);
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

    // state word of a lane: row is the role (a, b, c, d), diagonal rounds
    // shift the column by the row number
    function automatic logic [3:0] qr_idx(logic diag, logic [1:0] lane, logic [1:0] role);
        return {role, 2'(lane + (diag ? role : 2'd0))};
    endfunction

    function automatic block_t init_block(cfg_t cfg, word_t counter);
        block_t b;
        b[0]  = SIGMA_0;
        b[1]  = SIGMA_1;
        b[2]  = SIGMA_2;
        b[3]  = SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            b[4 + i] = cfg.key[i];
        end
        b[12] = counter;
        for (int i = 0; i < 3; i++) begin
            b[13 + i] = cfg.nonce[i];
        end
        return b;
    endfunction

endpackage

// File: hdl/cc20_if.sv
// ----------------------------------------------------------------------------
// cc20 channel interfaces
// valid/ready channels for byte input, byte result and register writes
// ----------------------------------------------------------------------------
interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_message;

    modport source (output valid, output data_byte, output first_of_message, input ready);
    modport sink (input valid, input data_byte, input first_of_message, output ready);
endinterface

interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink (input valid, input result_byte, output ready);
endinterface

interface cc20_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/cc20_front.sv
// ----------------------------------------------------------------------------
// cc20_front
// takes input beats, tags message restarts and queues them for the back end
// ----------------------------------------------------------------------------
module cc20_front
    import cc20_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cc20_in_if.sink feed,
    output item_t q_item,
    output logic  q_valid,
    input  logic  q_ready
);

    item_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;
    logic                  push;
    logic                  pop;
    item_t                 in_item;

    assign feed.ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_item     = slot_reg[rd_ptr_reg];

    assign push = feed.valid & feed.ready;
    assign pop  = q_valid & q_ready;

    // restart flag marks where the back end resets counter and position
    always_comb
    begin
        in_item.data    = feed.data_byte;
        in_item.restart = feed.first_of_message;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: hdl/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// block function: four lanes, half a quarter round per cycle, final add
// ----------------------------------------------------------------------------
module cc20_core
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  core_req_t req,
    output core_rsp_t rsp,
    output block_t    ks_block
);

    localparam int RW = $clog2(DOUBLE_ROUNDS);
    localparam logic [RW-1:0] LAST_ROUND = RW'(DOUBLE_ROUNDS - 1);

    core_state_t   state_reg;
    core_state_t   state_next;
    logic [RW-1:0] round_reg;
    logic [RW-1:0] round_next;
    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    block_t        x_reg;
    block_t        x_next;
    block_t        init_reg;
    block_t        rnd_block;
    quad_t         qin [4];
    quad_t         qout [4];
    logic          launch;

    // phase bit 1 selects diagonal rounds, bit 0 the second half
    always_comb
    begin
        rnd_block = x_reg;
        for (int lane = 0; lane < 4; lane++)
        begin
            qin[lane].a = x_reg[qr_idx(phase_reg[1], 2'(lane), 2'd0)];
            qin[lane].b = x_reg[qr_idx(phase_reg[1], 2'(lane), 2'd1)];
            qin[lane].c = x_reg[qr_idx(phase_reg[1], 2'(lane), 2'd2)];
            qin[lane].d = x_reg[qr_idx(phase_reg[1], 2'(lane), 2'd3)];
            qout[lane]  = half_qr(qin[lane], phase_reg[0]);
            rnd_block[qr_idx(phase_reg[1], 2'(lane), 2'd0)] = qout[lane].a;
            rnd_block[qr_idx(phase_reg[1], 2'(lane), 2'd1)] = qout[lane].b;
            rnd_block[qr_idx(phase_reg[1], 2'(lane), 2'd2)] = qout[lane].c;
            rnd_block[qr_idx(phase_reg[1], 2'(lane), 2'd3)] = qout[lane].d;
        end
    end

    assign launch = (state_reg == CORE_IDLE) && req.start && !req.abort;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (launch)
                begin
                    state_next = CORE_ROUND;
                    round_next = '0;
                    phase_next = '0;
                    x_next     = init_block(cfg, req.counter);
                end
            end
            CORE_ROUND:
            begin
                x_next     = rnd_block;
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    round_next = round_reg + RW'(1);
                    if (round_reg == LAST_ROUND)
                    begin
                        state_next = CORE_FINAL;
                    end
                end
            end
            CORE_FINAL:
            begin
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
        if (req.abort)
        begin
            state_next = CORE_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            round_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (launch)
        begin
            init_reg <= init_block(cfg, req.counter);
        end
    end

    // feed-forward add of the input state
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            ks_block[i] = x_reg[i] + init_reg[i];
        end
    end

    always_comb
    begin
        rsp.busy    = (state_reg != CORE_IDLE);
        rsp.done    = (state_reg == CORE_FINAL);
        rsp.counter = init_reg[12];
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("block done held for more than one cycle");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CORE_ROUND && phase_reg == 2'd3 && round_reg == LAST_ROUND
         && !req.abort) |=> rsp.done)
        else $error("last round step not followed by block done");

endmodule

// File: hdl/cc20_back.sv
// ----------------------------------------------------------------------------
// cc20_back
// holds current and prefetched keystream blocks, xors beats, drives result
// ----------------------------------------------------------------------------
module cc20_back
    import cc20_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      q_item,
    input  logic       q_valid,
    output logic       q_ready,
    input  logic       cfg_write,
    output core_req_t  req,
    input  core_rsp_t  rsp,
    input  block_t     ks_block,
    cc20_out_if.source result
);

    logic       cur_valid_reg;
    block_t     cur_reg;
    logic [5:0] pos_reg;
    word_t      ctr_reg;
    logic       pre_valid_reg;
    word_t      pre_ctr_reg;
    block_t     pre_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;

    logic       restart;
    word_t      want_ctr;
    logic       need_block;
    logic       pre_hit;
    logic       out_free;
    logic       consume;
    logic [5:0] use_pos;
    block_t     src_block;
    word_t      src_word;
    logic [7:0] ks_byte;

    // a restart beat wants block zero, otherwise the next counter
    assign restart    = q_valid & q_item.restart;
    assign want_ctr   = restart ? '0 : ctr_reg;
    assign need_block = restart | ~cur_valid_reg;
    assign pre_hit    = pre_valid_reg && (pre_ctr_reg == want_ctr);
    assign out_free   = !out_valid_reg || result.ready;
    assign q_ready    = out_free && (!need_block || pre_hit);
    assign consume    = q_valid & q_ready;

    assign use_pos   = restart ? '0 : pos_reg;
    assign src_block = need_block ? pre_reg : cur_reg;
    assign src_word  = src_block[use_pos[5:2]];
    assign ks_byte   = 8'(src_word >> {use_pos[1:0], 3'b000});

    // keep the core busy on whatever block is wanted next
    always_comb
    begin
        req.start   = !rsp.busy && !pre_hit && !cfg_write;
        req.abort   = cfg_write;
        req.counter = want_ctr;
    end

    assign result.valid       = out_valid_reg;
    assign result.result_byte = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            ctr_reg       <= '0;
            pre_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (consume)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= use_pos + 6'd1;
                cur_valid_reg <= (use_pos != LAST_POS);
                if (need_block)
                begin
                    ctr_reg <= want_ctr + 32'd1;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // new key or nonce makes the prefetch stale
            if (cfg_write)
            begin
                pre_valid_reg <= 1'b0;
            end
            else if (rsp.done)
            begin
                pre_valid_reg <= 1'b1;
            end
            else if (consume && need_block)
            begin
                pre_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            out_byte_reg <= q_item.data ^ ks_byte;
            if (need_block)
            begin
                cur_reg <= pre_reg;
            end
        end
        if (rsp.done && !cfg_write)
        begin
            pre_reg     <= ks_block;
            pre_ctr_reg <= rsp.counter;
        end
    end

    a_block_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cur_valid_reg) |-> $past(consume) && ($past(use_pos) == LAST_POS))
        else $error("keystream block dropped before its last byte");

    a_prefetch_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> pre_valid_reg || $past(cfg_write))
        else $error("finished block not held as prefetch");

endmodule

// File: hdl/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher: byte stream xor with the chacha20 keystream
// throughput: one byte per cycle sustained while result is ready and a block
//   is at hand; the core runs half a quarter round per cycle on four lanes
// path: input beat to queue slot to output register while a block is held;
//   a message start or a block change without prefetch waits on the core
// reset: counters, flags and key/nonce registers clear; keystream buffers don't
// ----------------------------------------------------------------------------
module chacha20_stream_cipher
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    cc20_in_if.sink    feed,
    cc20_out_if.source result,
    cc20_cfg_if.sink   cfg
);

    // key and nonce as state words, little-endian per register
    cfg_t      cfg_reg;
    logic      cfg_write;

    // front to back queue
    item_t     q_item;
    logic      q_valid;
    logic      q_ready;

    // back end to block core
    core_req_t core_req;
    core_rsp_t core_rsp;
    block_t    ks_block;

    // register port never stalls
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            // indexes past the list are dropped
            unique case (cfg_reg_t'(cfg.index))
                REG_KEY_0_7:    cfg_reg.key[1:0]   <= cfg.data;
                REG_KEY_8_15:   cfg_reg.key[3:2]   <= cfg.data;
                REG_KEY_16_23:  cfg_reg.key[5:4]   <= cfg.data;
                REG_KEY_24_31:  cfg_reg.key[7:6]   <= cfg.data;
                REG_NONCE_0_7:  cfg_reg.nonce[1:0] <= cfg.data;
                REG_NONCE_8_11: cfg_reg.nonce[2]   <= cfg.data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: accepts beats and queues them with their restart tag
    cc20_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .feed    (feed),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    // block core: runs the rounds for the counter the back end asks for
    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .req      (core_req),
        .rsp      (core_rsp),
        .ks_block (ks_block)
    );

    // back: current block, one prefetched block, output register
    cc20_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .cfg_write (cfg_write),
        .req       (core_req),
        .rsp       (core_rsp),
        .ks_block  (ks_block),
        .result    (result)
    );

endmodule

// File: verif/chacha20_stream_cipher_tb.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_tb
// drives byte streams and key/nonce writes into the stream cipher, builds
// each keystream block in a local scoreboard and checks every result beat
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_tb
    import cc20_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DOUBLE_ROUNDS = 10;
    // core time for one block plus margin, used whenever the block must go quiet
    localparam int IDLE_TAIL     = 4 * DOUBLE_ROUNDS + 2 + 24;
    localparam int RANDOM_ITEMS  = 930;
    localparam int MAX_GAP       = 17;

    // indexes past the register file, writes to them must be dropped
    localparam logic [2:0] REG_NONE_6 = 3'd6;
    localparam logic [2:0] REG_NONE_7 = 3'd7;

    // scoreboard: local copy of key, nonce, counter and position, plus the
    // queue of result bytes still owed by the block
    class keystream_scoreboard;
        word_t      key_w[8];
        word_t      nonce_w[3];
        word_t      block_ctr;
        logic [5:0] byte_pos;
        bit         block_valid;
        word_t      ks_w[16];
        word_t      mix_w[16];
        int         rounds;
        logic [7:0] expected_q[$];
        int         errors;

        function new(int n_double);
            rounds = n_double;
            errors = 0;
            foreach (key_w[i]) key_w[i] = '0;
            foreach (nonce_w[i]) nonce_w[i] = '0;
            block_ctr   = '0;
            byte_pos    = '0;
            block_valid = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_KEY_0_7:    begin key_w[0] = value[31:0]; key_w[1] = value[63:32]; end
                REG_KEY_8_15:   begin key_w[2] = value[31:0]; key_w[3] = value[63:32]; end
                REG_KEY_16_23:  begin key_w[4] = value[31:0]; key_w[5] = value[63:32]; end
                REG_KEY_24_31:  begin key_w[6] = value[31:0]; key_w[7] = value[63:32]; end
                REG_NONCE_0_7:  begin nonce_w[0] = value[31:0]; nonce_w[1] = value[63:32]; end
                REG_NONCE_8_11: nonce_w[2] = value[31:0];
                default: ;
            endcase
        endfunction

        function word_t rol(word_t v, int n);
            logic [63:0] twice;
            twice = {v, v} << n;
            return twice[63:32];
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix_w[a] = mix_w[a] + mix_w[b];
            mix_w[d] = rol(mix_w[d] ^ mix_w[a], 16);
            mix_w[c] = mix_w[c] + mix_w[d];
            mix_w[b] = rol(mix_w[b] ^ mix_w[c], 12);
            mix_w[a] = mix_w[a] + mix_w[b];
            mix_w[d] = rol(mix_w[d] ^ mix_w[a], 8);
            mix_w[c] = mix_w[c] + mix_w[d];
            mix_w[b] = rol(mix_w[b] ^ mix_w[c], 7);
        endfunction

        function void build_block();
            word_t seed_w[16];
            seed_w[0] = SIGMA_0;
            seed_w[1] = SIGMA_1;
            seed_w[2] = SIGMA_2;
            seed_w[3] = SIGMA_3;
            for (int i = 0; i < 8; i++) seed_w[4 + i] = key_w[i];
            seed_w[12] = block_ctr;
            for (int i = 0; i < 3; i++) seed_w[13 + i] = nonce_w[i];
            mix_w = seed_w;
            for (int r = 0; r < rounds; r++)
            begin
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) ks_w[i] = mix_w[i] + seed_w[i];
        endfunction

        function void note_input(logic [7:0] data, logic first);
            word_t shifted;
            if (first)
            begin
                block_ctr   = '0;
                byte_pos    = '0;
                block_valid = 1'b0;
            end
            if (!block_valid)
            begin
                build_block();
                block_ctr   = block_ctr + 1;
                block_valid = 1'b1;
            end
            shifted = ks_w[byte_pos[5:2]] >> {byte_pos[1:0], 3'b000};
            expected_q.push_back(data ^ shifted[7:0]);
            byte_pos = byte_pos + 1'b1;
            if (byte_pos == '0) block_valid = 1'b0;
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (expected_q.size() == 0)
            begin
                $error("result_byte beat with nothing expected: actual %02h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                $error("result_byte mismatch: expected %02h, actual %02h", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cc20_in_if  feed_if ();
    cc20_out_if result_if ();
    cc20_cfg_if cfg_if ();

    keystream_scoreboard sb = new(DOUBLE_ROUNDS);

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // hard stop well past the slowest legal run
    initial
    begin
        #10ms;
        $display("chacha20_stream_cipher test failed");
        $finish;
    end

    // monitor: every handshake is seen at the rising edge, before any of the
    // values driven at the following falling edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
                sb.write_reg(cfg_if.index, cfg_if.data);
            if (feed_if.valid === 1'b1 && feed_if.ready === 1'b1)
                sb.note_input(feed_if.data_byte, feed_if.first_of_message);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
                sb.check_result(result_if.result_byte);
        end
    end

    // result side: a random stall before every beat, with calm stretches
    // where ready just stays high
    initial
    begin
        int gap;
        int calm_left;
        bit calm;
        calm_left = 0;
        calm      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(20, 150);
            end
            calm_left--;
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (result_if.valid !== 1'b1) @(posedge clk);
        end
    end

    function automatic int pick_gap(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // key/nonce value with the all-zero and all-one extremes weighted in
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // one byte beat; valid stays high across back-to-back beats so it never
    // gets two assignments in one time step
    task automatic send_byte(logic [7:0] data, logic first, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            feed_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        feed_if.valid            <= 1'b1;
        feed_if.data_byte        <= data;
        feed_if.first_of_message <= first;
        @(posedge clk);
        while (feed_if.ready !== 1'b1) @(posedge clk);
    endtask

    task automatic go_quiet();
        @(negedge clk);
        feed_if.valid <= 1'b0;
    endtask

    // stop the byte stream, drain every owed result, then give the core time
    // to finish a prefetch that no result waits on
    task automatic settle();
        go_quiet();
        while (sb.pending() != 0) @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // random key/nonce update between messages, sometimes hitting a dead index
    task automatic reconfigure();
        cfg_reg_t r;
        settle();
        r = r.first();
        do
        begin
            if ($urandom_range(0, 1) == 1) write_reg(r, pick_value());
            r = r.next();
        end
        while (r != r.first());
        if ($urandom_range(0, 5) == 0)
            write_reg($urandom_range(0, 1) ? REG_NONE_7 : REG_NONE_6, pick_value());
    endtask

    initial
    begin
        int  sent;
        int  len;
        int  pick;
        bit  calm;
        bit  lead;
        feed_if.valid            = 1'b0;
        feed_if.data_byte        = '0;
        feed_if.first_of_message = 1'b0;
        result_if.ready          = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.index             = '0;
        cfg_if.data              = '0;
        rst_n                    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset key and nonce, stream starting without a first flag
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'hff, 1'b0, 0);
        send_byte(8'h55, 1'b0, 3);
        send_byte(8'haa, 1'b0, 0);
        // restart mid-block, then continue
        send_byte(8'h00, 1'b1, 0);
        send_byte(8'h80, 1'b0, 0);
        send_byte(8'h01, 1'b0, 5);
        send_byte(8'h7f, 1'b0, 0);

        // all-ones key and nonce; dead indexes must not disturb them
        settle();
        write_reg(REG_KEY_0_7, '1);
        write_reg(REG_KEY_8_15, '1);
        write_reg(REG_KEY_16_23, '1);
        write_reg(REG_KEY_24_31, '1);
        write_reg(REG_NONCE_0_7, '1);
        write_reg(REG_NONCE_8_11, '1);
        write_reg(REG_NONE_6, {$urandom(), $urandom()});
        write_reg(REG_NONE_7, {$urandom(), $urandom()});
        send_byte(8'hff, 1'b1, 0);
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'h3c, 1'b0, 0);

        // back-to-back one-byte messages
        send_byte(8'hc3, 1'b1, 0);
        send_byte(8'h96, 1'b1, 0);
        send_byte(8'h69, 1'b1, 2);

        // counting key with a well-known nonce, zero data shows the raw keystream
        settle();
        write_reg(REG_KEY_0_7, 64'h0706050403020100);
        write_reg(REG_KEY_8_15, 64'h0f0e0d0c0b0a0908);
        write_reg(REG_KEY_16_23, 64'h1716151413121110);
        write_reg(REG_KEY_24_31, 64'h1f1e1d1c1b1a1918);
        write_reg(REG_NONCE_0_7, 64'h4a000000_09000000);
        write_reg(REG_NONCE_8_11, 64'h0);
        for (int i = 0; i < 8; i++) send_byte(8'h00, i == 0, 0);

        // random messages: most are well formed streams that can run over block
        // boundaries, some are short bursts and stray restarts
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0) reconfigure();
            pick = $urandom_range(0, 9);
            if (pick < 2)
                len = $urandom_range(1, 8);
            else if (pick < 8)
                len = $urandom_range(40, 140);
            else
                len = $urandom_range(150, 280);
            // last message is cut to the byte budget
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            calm = ($urandom_range(0, 3) == 0);
            // a few messages carry on the previous stream without a restart
            lead = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < len; i++)
            begin
                send_byte(8'($urandom_range(0, 255)),
                          (i == 0) ? lead : ($urandom_range(0, 255) == 0),
                          pick_gap(calm));
                sent++;
            end
        end

        // drain and watch for stray beats
        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("chacha20_stream_cipher test passed");
        else
            $display("chacha20_stream_cipher test failed");
        $finish;
    end

endmodule
